// ----- hdl/aaid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaid_pkg
// Shared constants, types and state codes of the area averaging downscaler.
// ----------------------------------------------------------------------------
package aaid_pkg;

  localparam int MAX_DST_W = 256;
  localparam int MAX_DST_H = 256;
  localparam int SRC_BITS  = 16;
  localparam int DST_BITS  = 9;
  localparam int FRAC_BITS = 12;
  localparam int OUT_SHIFT = 24;
  localparam int NCH       = 3;
  localparam int ACC_BITS  = 32;
  localparam int CH_BITS   = 8;

  localparam int COL_AW  = $clog2(MAX_DST_W);
  localparam int ROW_AW  = $clog2(MAX_DST_H);
  localparam int W_BITS  = FRAC_BITS + 1;
  localparam int WP_BITS = 2 * W_BITS;
  localparam int DIV_NW  = DST_BITS + FRAC_BITS;
  localparam int DIV_CW  = $clog2(DIV_NW);
  localparam int REG_IDX_BITS = 3;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_SRC_W     = 3'd0,
    REG_SRC_H     = 3'd1,
    REG_DST_W     = 3'd2,
    REG_DST_H     = 3'd3,
    REG_BOTTOM_UP = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_N,
    ST_B_NWAIT,
    ST_B_QWAIT,
    ST_B_ENTRY,
    ST_B_RWAIT,
    ST_RD,
    ST_W,
    ST_M,
    ST_WB0,
    ST_WB1
  } state_t;

  typedef struct packed {
    logic [SRC_BITS-1:0] bnd;
    logic [W_BITS-1:0]   lw;
    logic [W_BITS-1:0]   rw;
  } edge_t;

  typedef struct packed {
    logic [SRC_BITS-1:0] src_w;
    logic [SRC_BITS-1:0] src_h;
    logic [DST_BITS-1:0] dst_w;
    logic [DST_BITS-1:0] dst_h;
    logic                bottom_up;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic [7:0]         col;
    logic [7:0]         row;
    logic               done;
  } res_t;

  typedef logic [NCH-1:0][ACC_BITS-1:0] rgb_t;

endpackage

// ----- hdl/aaid_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaid interfaces
// Pixel, result and configuration channels, valid/ready per beat.
// ----------------------------------------------------------------------------
interface aaid_pix_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, action, red, green, blue, input ready);
  modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface aaid_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_col;
  logic [7:0] out_row;
  logic       frame_done;
  modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                  frame_done, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_col, out_row,
                  frame_done, output ready);
endinterface

interface aaid_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/aaid_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaid_front
// Configuration registers and a two-entry queue of incoming beats.
// ----------------------------------------------------------------------------
module aaid_front import aaid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_ready,
  input  item_t      pix_item,
  input  logic       cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t       cfg,
  output head_t      head,
  input  logic       pop
);

  item_t      fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign pix_ready = (count != 2'd2);
  assign push      = pix_valid && pix_ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= pix_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // take register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_w     <= SRC_BITS'(1);
      cfg.src_h     <= SRC_BITS'(1);
      cfg.dst_w     <= DST_BITS'(1);
      cfg.dst_h     <= DST_BITS'(1);
      cfg.bottom_up <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SRC_W:     cfg.src_w     <= cfg_data[SRC_BITS-1:0];
        REG_SRC_H:     cfg.src_h     <= cfg_data[SRC_BITS-1:0];
        REG_DST_W:     cfg.dst_w     <= cfg_data[DST_BITS-1:0];
        REG_DST_H:     cfg.dst_h     <= cfg_data[DST_BITS-1:0];
        REG_BOTTOM_UP: cfg.bottom_up <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/aaid_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaid_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aaid_div import aaid_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_NW-1:0]   num,
  input  logic [SRC_BITS-1:0] den,
  output logic                done,
  output logic [DIV_NW-1:0]   quo,
  output logic [SRC_BITS-1:0] rem
);

  logic                busy;
  logic [DIV_CW-1:0]   cnt;
  logic [SRC_BITS-1:0] den_r;
  logic [SRC_BITS:0]   shifted;
  logic                ge;

  assign shifted = {rem, quo[DIV_NW-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[DIV_NW-2:0], ge};
      rem <= ge ? SRC_BITS'(shifted - {1'b0, den_r}) : shifted[SRC_BITS-1:0];
    end
  end

endmodule

// ----- hdl/aaid_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaid_back
// Table builder and pixel engine: edge tables, accumulators, result register.
// ----------------------------------------------------------------------------
module aaid_back import aaid_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  head_t head,
  output logic  pop,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  state_t state, state_next;

  // frame state
  logic                active;
  logic [DST_BITS-1:0] fr_dw, fr_dh;
  logic                fr_flip;
  logic [W_BITS-1:0]   norm_x, norm_y;
  logic [SRC_BITS-1:0] src_col, src_row;
  logic [COL_AW-1:0]   sec_col;
  logic [ROW_AW-1:0]   sec_row;
  rgb_t                carry;
  logic [NCH-1:0][CH_BITS-1:0] px;

  // table build
  logic                tb_row;
  logic [SRC_BITS-1:0] tb_olen;
  logic [DST_BITS-1:0] tb_nlen;
  logic [W_BITS-1:0]   tb_n, rprev;
  logic [SRC_BITS-1:0] qstep;
  logic [DST_BITS-1:0] rstep, m;
  logic [SRC_BITS:0]   b;
  logic [DST_BITS-1:0] idx;
  logic [DST_BITS:0]   m_sum;
  logic                m_wrap;
  logic [DST_BITS-1:0] m_new;
  logic [SRC_BITS:0]   b_new;
  logic                tb_last;

  // divider
  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num, div_quo;
  logic [SRC_BITS-1:0] div_den, div_rem;

  // memories
  edge_t col_mem [MAX_DST_W];
  edge_t row_mem [MAX_DST_H];
  rgb_t  acc_mem [MAX_DST_W];
  logic  tbl_we;
  edge_t tbl_wd;
  logic  acc_we;
  logic [COL_AW-1:0] acc_wa;
  rgb_t  acc_wd;
  logic  rd_en;
  edge_t colk_q, colk1_q, rowk_q, rowk1_q;
  rgb_t  acck_q, acck1_q;

  // pixel pipeline
  logic                redge, interior, k1_ok, sr1_ok;
  logic [W_BITS-1:0]   ylast, ynext, cw;
  logic                redge_r, interior_r, k1ok_r, sr1ok_r;
  logic [WP_BITS-1:0]  w [4];
  rgb_t                p [4];
  rgb_t                acc_sum, acc_edge, acc1_sum;
  logic                emit, res_load, frame_bad;

  aaid_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign frame_bad = (cfg.src_w == '0) || (cfg.src_h == '0) ||
                     (cfg.dst_w == '0) || (cfg.dst_h == '0) ||
                     (SRC_BITS'(cfg.dst_w) > cfg.src_w) ||
                     (SRC_BITS'(cfg.dst_h) > cfg.src_h) ||
                     (cfg.dst_w > DST_BITS'(MAX_DST_W)) ||
                     (cfg.dst_h > DST_BITS'(MAX_DST_H));

  // incremental sum / nlen: quotient and remainder advance by olen / nlen
  assign m_sum  = {1'b0, m} + {1'b0, rstep};
  assign m_wrap = m_sum >= {1'b0, tb_nlen};
  assign m_new  = m_wrap ? DST_BITS'(m_sum - {1'b0, tb_nlen}) : m_sum[DST_BITS-1:0];
  assign b_new  = b + (SRC_BITS + 1)'(qstep) + (SRC_BITS + 1)'(m_wrap);
  assign tb_last = (idx == tb_nlen - 1'b1);

  // row and column weights from the table reads
  assign redge  = (src_row == rowk_q.bnd);
  assign sr1_ok = ({1'b0, sec_row} + 1'b1) < fr_dh;
  assign k1_ok  = ({1'b0, sec_col} + 1'b1) < fr_dw;
  assign interior = src_col < colk_q.bnd;
  assign ylast  = redge ? rowk_q.rw : norm_y;
  assign ynext  = (redge && sr1_ok) ? rowk1_q.lw : '0;
  assign cw     = interior ? norm_x : colk_q.rw;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      acc_sum[c]  = acck_q[c] + p[0][c];
      acc_edge[c] = carry[c] + p[1][c];
      acc1_sum[c] = acck1_q[c] + p[2][c];
    end
  end

  assign emit     = !interior_r && redge_r;
  assign res_load = (state == ST_WB0) && emit && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    tbl_we     = 1'b0;
    tbl_wd     = '0;
    acc_we     = 1'b0;
    acc_wa     = sec_col;
    acc_wd     = '0;
    rd_en      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.action == ACT_START) begin
            if (!frame_bad) state_next = ST_B_N;
          end else if (active) begin
            state_next = ST_RD;
          end
        end
      end
      ST_B_N: begin
        div_start  = 1'b1;
        div_num    = {tb_nlen, FRAC_BITS'(0)};
        div_den    = tb_olen;
        state_next = ST_B_NWAIT;
      end
      ST_B_NWAIT: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = DIV_NW'(tb_olen);
          div_den    = SRC_BITS'(tb_nlen);
          state_next = ST_B_QWAIT;
        end
      end
      ST_B_QWAIT: begin
        if (div_done) state_next = ST_B_ENTRY;
      end
      ST_B_ENTRY: begin
        if (m_new == '0) begin
          tbl_we    = 1'b1;
          tbl_wd.bnd = SRC_BITS'(b_new - 1'b1);
          tbl_wd.lw = tb_n - rprev;
          tbl_wd.rw = tb_n;
          if (tb_last) begin
            state_next = tb_row ? ST_IDLE : ST_B_N;
          end
        end else begin
          div_start  = 1'b1;
          div_num    = DIV_NW'({m_new, FRAC_BITS'(0)});
          div_den    = tb_olen;
          state_next = ST_B_RWAIT;
        end
      end
      ST_B_RWAIT: begin
        if (div_done) begin
          tbl_we     = 1'b1;
          tbl_wd.bnd = b[SRC_BITS-1:0];
          tbl_wd.lw  = tb_n - rprev;
          tbl_wd.rw  = div_quo[W_BITS-1:0];
          if (tb_last) begin
            state_next = tb_row ? ST_IDLE : ST_B_N;
          end else begin
            state_next = ST_B_ENTRY;
          end
        end
      end
      ST_RD: begin
        rd_en      = 1'b1;
        state_next = ST_W;
      end
      ST_W: state_next = ST_M;
      ST_M: state_next = ST_WB0;
      ST_WB0: begin
        if (!emit || !res_valid || res_ready) begin
          acc_we = 1'b1;
          acc_wd = emit ? acc_edge : acc_sum;
          state_next = (!interior_r && k1ok_r) ? ST_WB1 : ST_IDLE;
        end
      end
      ST_WB1: begin
        acc_we     = 1'b1;
        acc_wa     = sec_col + 1'b1;
        acc_wd     = acc1_sum;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    // clear the accumulators alongside the column table
    if (tbl_we && !tb_row) begin
      acc_we = 1'b1;
      acc_wa = idx[COL_AW-1:0];
      acc_wd = '0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (tbl_we && !tb_row) col_mem[idx[COL_AW-1:0]] <= tbl_wd;
    if (tbl_we && tb_row) row_mem[idx[ROW_AW-1:0]] <= tbl_wd;
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      colk_q  <= col_mem[sec_col];
      colk1_q <= col_mem[sec_col + 1'b1];
      rowk_q  <= row_mem[sec_row];
      rowk1_q <= row_mem[sec_row + 1'b1];
      acck_q  <= acc_mem[sec_col];
      acck1_q <= acc_mem[sec_col + 1'b1];
    end
  end

  // table build datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        tb_row  <= 1'b0;
        tb_olen <= cfg.src_w;
        tb_nlen <= cfg.dst_w;
      end
      ST_B_NWAIT: begin
        if (div_done) tb_n <= div_quo[W_BITS-1:0];
      end
      ST_B_QWAIT: begin
        if (div_done) begin
          qstep <= div_quo[SRC_BITS-1:0];
          rstep <= div_rem[DST_BITS-1:0];
          idx   <= '0;
          m     <= '0;
          b     <= '0;
          rprev <= '0;
        end
      end
      ST_B_ENTRY: begin
        m <= m_new;
        b <= b_new;
      end
      default: ;
    endcase
    if (tbl_we) begin
      rprev <= tbl_wd.rw;
      idx   <= idx + 1'b1;
      if (tb_last && !tb_row) begin
        tb_row  <= 1'b1;
        tb_olen <= cfg.src_h;
        tb_nlen <= fr_dh;
      end
    end
  end

  // pixel pipeline datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && head.valid) begin
      px[0] <= head.item.red;
      px[1] <= head.item.green;
      px[2] <= head.item.blue;
    end
    if (state == ST_W) begin
      redge_r    <= redge;
      interior_r <= interior;
      k1ok_r     <= k1_ok;
      sr1ok_r    <= sr1_ok;
      w[0] <= WP_BITS'(ylast) * WP_BITS'(cw);
      w[1] <= WP_BITS'(ynext) * WP_BITS'(cw);
      w[2] <= WP_BITS'(ylast) * WP_BITS'(colk1_q.lw);
      w[3] <= WP_BITS'(ynext) * WP_BITS'(colk1_q.lw);
    end
    if (state == ST_M) begin
      for (int j = 0; j < 4; j++) begin
        for (int c = 0; c < NCH; c++) begin
          p[j][c] <= ACC_BITS'(w[j]) * ACC_BITS'(px[c]);
        end
      end
    end
    if (res_load) begin
      res.red   <= acc_sum[0][OUT_SHIFT +: CH_BITS];
      res.green <= acc_sum[1][OUT_SHIFT +: CH_BITS];
      res.blue  <= acc_sum[2][OUT_SHIFT +: CH_BITS];
      res.col   <= sec_col;
      res.row   <= fr_flip ? 8'(fr_dh - 1'b1 - DST_BITS'(sec_row)) : 8'(sec_row);
      res.done  <= !k1ok_r && !sr1ok_r;
    end
  end

  // frame control
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      res_valid <= 1'b0;
      src_col   <= '0;
      src_row   <= '0;
      sec_col   <= '0;
      sec_row   <= '0;
      carry     <= '0;
      fr_dw     <= DST_BITS'(1);
      fr_dh     <= DST_BITS'(1);
      fr_flip   <= 1'b0;
      norm_x    <= '0;
      norm_y    <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid && head.item.action == ACT_START) begin
            active <= 1'b0;
            if (!frame_bad) begin
              src_col <= '0;
              src_row <= '0;
              sec_col <= '0;
              sec_row <= '0;
              carry   <= '0;
              fr_dw   <= cfg.dst_w;
              fr_dh   <= cfg.dst_h;
              fr_flip <= cfg.bottom_up;
            end
          end
        end
        ST_B_ENTRY, ST_B_RWAIT: begin
          if (tbl_we && tb_last) begin
            if (tb_row) begin
              norm_y <= tb_n;
              active <= 1'b1;
            end else begin
              norm_x <= tb_n;
            end
          end
        end
        ST_WB0: begin
          if (acc_we) begin
            if (interior_r) begin
              src_col <= src_col + 1'b1;
              if (redge_r) begin
                for (int c = 0; c < NCH; c++) carry[c] <= carry[c] + p[1][c];
              end
            end else if (!k1ok_r) begin
              // end of a source row: wrap to the first column section
              src_col <= '0;
              sec_col <= '0;
              carry   <= '0;
              src_row <= src_row + 1'b1;
              if (redge_r) begin
                if (sr1ok_r) begin
                  sec_row <= sec_row + 1'b1;
                end else begin
                  active <= 1'b0;
                end
              end
            end
          end
        end
        ST_WB1: begin
          src_col <= src_col + 1'b1;
          sec_col <= sec_col + 1'b1;
          if (redge_r) carry <= p[3];
        end
        default: ;
      endcase
    end
  end

  a_wb1_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_WB1 |-> $past(state) == ST_WB0)
    else $error("second accumulator write without a first");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_B_NWAIT || state == ST_B_QWAIT || state == ST_B_RWAIT))
    else $error("divider result arrived outside a wait state");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (res_load && !k1ok_r && !sr1ok_r) |=> !active)
    else $error("frame stays active after its final pixel");

endmodule

// ----- hdl/area_average_image_downscaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_average_image_downscaler
// Area averaging RGB thumbnail engine with a decoupled queue and engine.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  - register writes (index, data); always ready. Write only while idle.
//   pix  - one beat per item: action 0 starts a frame, action 1 is a pixel.
//   res  - one beat per thumbnail pixel, with column, row and frame_done.
// A two-entry queue takes pix beats while the engine works or a result waits.
// Each pixel passes the engine states idle, read, weight, multiply and first
// write, plus the second accumulator write when it closes a column section
// that is not the last of the row. A start beat builds the column then the
// row edge tables with a bit-serial divider: two quotients set up each table,
// then the dst_width + dst_height entries are written, each after one more
// quotient if it needs a fractional edge weight. A start with a bad geometry
// is dropped and pixels are ignored until the next good start. A result is
// shown in the cycle after the pixel's first write stage; when res stalls,
// the engine holds at that stage and the queue then fills and drops pix
// ready. Reset clears the queue, the counters and the frame; the tables and
// accumulators are rebuilt by every good start.
// ----------------------------------------------------------------------------
module area_average_image_downscaler import aaid_pkg::*; (
  input  logic clk,
  input  logic rst,
  aaid_pix_if.sink   pix,
  aaid_res_if.source res,
  aaid_cfg_if.sink   cfg
);

  cfg_t  cfg_regs;
  head_t head;
  logic  pop;
  item_t pix_item;
  res_t  res_data;

  // pack the pixel beat
  assign pix_item.action = pix.action;
  assign pix_item.red    = pix.red;
  assign pix_item.green  = pix.green;
  assign pix_item.blue   = pix.blue;

  // register writes always land at once
  assign cfg.ready = 1'b1;

  aaid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .pix_item  (pix_item),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .cfg       (cfg_regs),
    .head      (head),
    .pop       (pop)
  );

  aaid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .head      (head),
    .pop       (pop),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res       (res_data)
  );

  // unpack the result beat
  assign res.out_red    = res_data.red;
  assign res.out_green  = res_data.green;
  assign res.out_blue   = res_data.blue;
  assign res.out_col    = res_data.col;
  assign res.out_row    = res_data.row;
  assign res.frame_done = res_data.done;

endmodule
